>>> hw/rtl/overwriting_history_ring_buffer_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the history ring buffer
// Concurrent checks clocked on i_clk, disabled while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef OVERWRITING_HISTORY_RING_BUFFER_ASSERT_SVH
`define OVERWRITING_HISTORY_RING_BUFFER_ASSERT_SVH

`ifndef SYNTH

// same-cycle implication
`define OHRB_ASSERT_IMPLIES(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("ohrb assertion failed");

// next-cycle implication
`define OHRB_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("ohrb assertion failed");

`else

`define OHRB_ASSERT_IMPLIES(label, ante, cons)
`define OHRB_ASSERT_NEXT(label, ante, cons)

`endif

`endif

>>> hw/rtl/ohrb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ohrb_pkg
// Shared constants, command codes and control structs of the history buffer.
// ----------------------------------------------------------------------------
package ohrb_pkg;

    localparam int CAPACITY_DEF   = 32;
    localparam int FRAME_BITS_DEF = 64;

    localparam int CMD_W       = 2;
    localparam int OFFSET_W    = 6;
    localparam int RUN_W       = 7;
    localparam int COUNT_OUT_W = 6;

    localparam logic [CMD_W-1:0] CMD_PUSH = 2'd0;
    localparam logic [CMD_W-1:0] CMD_READ = 2'd1;
    localparam logic [CMD_W-1:0] CMD_COPY = 2'd2;

    // controller -> datapath
    typedef struct packed {
        logic push;          // write frame, advance pointer, count up until full
        logic load_single;   // load a one-result answer without frame data
        logic single_found;
        logic read_issue;    // read at offset from newest
        logic copy_start;    // read first frame of a run
        logic emit;          // load result from memory read data
        logic emit_last;
    } t_dp_cmd;

    // datapath -> controller
    typedef struct packed {
        logic read_hit;
        logic copy_ok;
        logic last_elem;
        logic out_free;
    } t_dp_stat;

endpackage

>>> hw/rtl/ohrb_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ohrb_in_if
// Command channel: valid/ready handshake with command and operands.
// ----------------------------------------------------------------------------
interface ohrb_in_if #(
    parameter int FRAME_BITS = ohrb_pkg::FRAME_BITS_DEF
);
    import ohrb_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [CMD_W-1:0]      command;
    logic [FRAME_BITS-1:0] frame_word;
    logic [OFFSET_W-1:0]   offset;
    logic [RUN_W-1:0]      run_length;

    modport source (
        output valid, command, frame_word, offset, run_length,
        input  ready
    );

    modport sink (
        input  valid, command, frame_word, offset, run_length,
        output ready
    );

endinterface

>>> hw/rtl/ohrb_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ohrb_out_if
// Result channel: valid/ready handshake with frame data and status.
// ----------------------------------------------------------------------------
interface ohrb_out_if #(
    parameter int FRAME_BITS = ohrb_pkg::FRAME_BITS_DEF
);
    import ohrb_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [FRAME_BITS-1:0]  rd_frame;
    logic                   found;
    logic [COUNT_OUT_W-1:0] stored_count;
    logic                   last;

    modport source (
        output valid, rd_frame, found, stored_count, last,
        input  ready
    );

    modport sink (
        input  valid, rd_frame, found, stored_count, last,
        output ready
    );

endinterface

>>> hw/rtl/overwriting_history_ring_buffer.sv
// Push, failed read/copy and unused commands: result in the cycle after the transfer,
//   one item per cycle while the result side keeps up.
// Read hit: registered memory read, then output register; input waits for the result.
// Copy of N frames: N results at one per cycle while the result side keeps up, after
//   the registered read of the first frame, paced by the single memory read port.
// Reset clears write pointer, frame count and output valid; frame memory is not cleared.
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// overwriting_history_ring_buffer
// Fixed-capacity frame history that overwrites the oldest frame on push.
// ----------------------------------------------------------------------------
`include "overwriting_history_ring_buffer_assert.svh"

module overwriting_history_ring_buffer #(
    parameter int CAPACITY   = ohrb_pkg::CAPACITY_DEF,
    parameter int FRAME_BITS = ohrb_pkg::FRAME_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ohrb_in_if.sink     i_in,
    ohrb_out_if.source  o_out
);
    import ohrb_pkg::*;

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;
    logic     w_in_ready;
    logic     w_accept;
    logic     w_push_acc;
    logic     w_read_acc;
    logic     w_copy_nak;

    ohrb_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_in.valid),
        .i_command (i_in.command),
        .i_stat    (w_stat),
        .o_ready   (w_in_ready),
        .o_cmd     (w_cmd)
    );

    ohrb_datapath #(
        .CAPACITY   (CAPACITY),
        .FRAME_BITS (FRAME_BITS)
    ) u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .i_frame_word (i_in.frame_word),
        .i_offset     (i_in.offset),
        .i_run_length (i_in.run_length),
        .i_out_ready  (o_out.ready),
        .o_stat       (w_stat),
        .o_out_valid  (o_out.valid),
        .o_out_data   (o_out.rd_frame),
        .o_out_found  (o_out.found),
        .o_out_count  (o_out.stored_count),
        .o_out_last   (o_out.last)
    );

    assign i_in.ready = w_in_ready;
    assign w_accept   = i_in.valid && w_in_ready;
    assign w_push_acc = w_accept && (i_in.command == CMD_PUSH);
    assign w_read_acc = w_accept && (i_in.command == CMD_READ) && w_stat.read_hit;
    assign w_copy_nak = w_accept && (i_in.command == CMD_COPY) && !w_stat.copy_ok;

    `OHRB_ASSERT_NEXT(a_push_result, w_push_acc, o_out.valid && o_out.found && o_out.last)
    `OHRB_ASSERT_NEXT(a_read_hit_timing, w_read_acc, !o_out.valid ##1 (o_out.valid && o_out.last))
    `OHRB_ASSERT_NEXT(a_copy_refused, w_copy_nak, o_out.valid && !o_out.found && o_out.last)
    `OHRB_ASSERT_IMPLIES(a_busy_blocks_input, w_cmd.emit || w_cmd.read_issue, !w_cmd.load_single)

endmodule

>>> hw/rtl/ohrb_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ohrb_ctrl
// Command sequencer: decodes accepted commands and steps reads and copy runs.
// ----------------------------------------------------------------------------
module ohrb_ctrl (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    input  logic [ohrb_pkg::CMD_W-1:0]  i_command,
    input  ohrb_pkg::t_dp_stat          i_stat,
    output logic                        o_ready,
    output ohrb_pkg::t_dp_cmd           o_cmd
);
    import ohrb_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_READ = 2'd1;
    localparam logic [1:0] S_COPY = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;
    logic       w_accept;

    assign o_ready  = (r_state == S_IDLE) && i_stat.out_free;
    assign w_accept = i_valid && o_ready;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    case (i_command)
                        CMD_PUSH: begin
                            o_cmd.push         = 1'b1;
                            o_cmd.load_single  = 1'b1;
                            o_cmd.single_found = 1'b1;
                        end
                        CMD_READ: begin
                            if (i_stat.read_hit) begin
                                o_cmd.read_issue = 1'b1;
                                n_state          = S_READ;
                            end else begin
                                o_cmd.load_single = 1'b1;
                            end
                        end
                        CMD_COPY: begin
                            if (i_stat.copy_ok) begin
                                o_cmd.copy_start = 1'b1;
                                n_state          = S_COPY;
                            end else begin
                                o_cmd.load_single = 1'b1;
                            end
                        end
                        default: begin
                            o_cmd.load_single = 1'b1;
                        end
                    endcase
                end
            end
            S_READ: begin
                // output register was drained when the read was accepted
                o_cmd.emit      = 1'b1;
                o_cmd.emit_last = 1'b1;
                n_state         = S_IDLE;
            end
            S_COPY: begin
                if (i_stat.out_free) begin
                    o_cmd.emit      = 1'b1;
                    o_cmd.emit_last = i_stat.last_elem;
                    if (i_stat.last_elem) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

>>> hw/rtl/ohrb_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ohrb_datapath
// Frame memory, write pointer, frame count, run counter and output register.
// ----------------------------------------------------------------------------
module ohrb_datapath #(
    parameter int CAPACITY   = ohrb_pkg::CAPACITY_DEF,
    parameter int FRAME_BITS = ohrb_pkg::FRAME_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  ohrb_pkg::t_dp_cmd                 i_cmd,
    input  logic [FRAME_BITS-1:0]             i_frame_word,
    input  logic [ohrb_pkg::OFFSET_W-1:0]     i_offset,
    input  logic [ohrb_pkg::RUN_W-1:0]        i_run_length,
    input  logic                              i_out_ready,
    output ohrb_pkg::t_dp_stat                o_stat,
    output logic                              o_out_valid,
    output logic [FRAME_BITS-1:0]             o_out_data,
    output logic                              o_out_found,
    output logic [ohrb_pkg::COUNT_OUT_W-1:0]  o_out_count,
    output logic                              o_out_last
);
    import ohrb_pkg::*;

    localparam int PTR_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int CMP_W = (CNT_W > RUN_W) ? CNT_W : RUN_W;
    localparam int SUM_W = CMP_W + 1;

    logic [FRAME_BITS-1:0]  r_mem [CAPACITY];
    logic [FRAME_BITS-1:0]  r_rdata;
    logic [PTR_W-1:0]       r_wp;
    logic [PTR_W-1:0]       n_wp;
    logic [CNT_W-1:0]       r_count;
    logic [CNT_W-1:0]       n_count;
    logic [PTR_W-1:0]       r_cur;
    logic [RUN_W-1:0]       r_remain;
    logic                   r_out_valid;
    logic [FRAME_BITS-1:0]  r_out_data;
    logic                   r_out_found;
    logic [COUNT_OUT_W-1:0] r_out_count;
    logic                   r_out_last;

    logic [CMP_W-1:0]       w_cnt_cmp;
    logic [CMP_W-1:0]       w_run_cmp;
    logic [SUM_W-1:0]       w_sum_rd;
    logic [SUM_W-1:0]       w_sum_cp;
    logic [PTR_W-1:0]       w_idx_rd;
    logic [PTR_W-1:0]       w_idx_cp;
    logic [PTR_W-1:0]       w_next_cur;
    logic [PTR_W-1:0]       w_rd_addr;

    assign w_cnt_cmp = CMP_W'(r_count);
    assign w_run_cmp = CMP_W'(i_run_length);

    assign o_stat.read_hit  = CMP_W'(i_offset) < w_cnt_cmp;
    assign o_stat.copy_ok   = (i_run_length != '0) && (w_run_cmp <= CMP_W'(CAPACITY))
                              && (w_run_cmp <= w_cnt_cmp);
    assign o_stat.last_elem = (r_remain == RUN_W'(1));
    assign o_stat.out_free  = !r_out_valid || i_out_ready;

    // newest is wp-1; wrap once back into range
    assign w_sum_rd = SUM_W'(r_wp) + SUM_W'(CAPACITY - 1) - SUM_W'(i_offset);
    assign w_sum_cp = SUM_W'(r_wp) + SUM_W'(CAPACITY) - SUM_W'(i_run_length);
    assign w_idx_rd = (w_sum_rd >= SUM_W'(CAPACITY)) ? PTR_W'(w_sum_rd - SUM_W'(CAPACITY))
                                                     : PTR_W'(w_sum_rd);
    assign w_idx_cp = (w_sum_cp >= SUM_W'(CAPACITY)) ? PTR_W'(w_sum_cp - SUM_W'(CAPACITY))
                                                     : PTR_W'(w_sum_cp);
    assign w_next_cur = (r_cur == PTR_W'(CAPACITY - 1)) ? '0 : r_cur + PTR_W'(1);

    // hold the address while stalled so read data stays put
    always_comb begin
        if (i_cmd.copy_start) begin
            w_rd_addr = w_idx_cp;
        end else if (i_cmd.read_issue) begin
            w_rd_addr = w_idx_rd;
        end else if (i_cmd.emit) begin
            w_rd_addr = w_next_cur;
        end else begin
            w_rd_addr = r_cur;
        end
    end

    always_comb begin
        n_wp    = r_wp;
        n_count = r_count;
        if (i_cmd.push) begin
            n_wp = (r_wp == PTR_W'(CAPACITY - 1)) ? '0 : r_wp + PTR_W'(1);
            if (r_count != CNT_W'(CAPACITY)) begin
                n_count = r_count + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            r_mem[r_wp] <= i_frame_word;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[w_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp        <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_wp    <= n_wp;
            r_count <= n_count;
            if (i_cmd.load_single || i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.copy_start) begin
            r_cur    <= w_idx_cp;
            r_remain <= i_run_length;
        end else if (i_cmd.emit) begin
            r_cur    <= w_next_cur;
            r_remain <= r_remain - RUN_W'(1);
        end
        if (i_cmd.load_single) begin
            r_out_data  <= '0;
            r_out_found <= i_cmd.single_found;
            r_out_count <= COUNT_OUT_W'(n_count);
            r_out_last  <= 1'b1;
        end else if (i_cmd.emit) begin
            r_out_data  <= r_rdata;
            r_out_found <= 1'b1;
            r_out_count <= COUNT_OUT_W'(r_count);
            r_out_last  <= i_cmd.emit_last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;
    assign o_out_found = r_out_found;
    assign o_out_count = r_out_count;
    assign o_out_last  = r_out_last;

endmodule
